// ----- hdl/cat_pkg.sv -----
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants of the channel activity table.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam logic [2:0] OP_UPDATE  = 3'd0;
    localparam logic [2:0] OP_BLACK   = 3'd1;
    localparam logic [2:0] OP_GOOD    = 3'd2;
    localparam logic [2:0] OP_STANDBY = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_REMOVE  = 3'd5;
    localparam logic [2:0] OP_READ    = 3'd6;

    localparam logic [15:0] NOISE_INIT = 16'hFFFF;

    // One table entry as held by a cell.
    typedef struct packed {
        logic [31:0] freq;
        logic [31:0] first_seen;
        logic [31:0] last_check;
        logic [31:0] last_opened;
        logic [31:0] open_total;
        logic [15:0] rssi;
        logic [15:0] noise;
        logic        fl_open;
        logic        fl_black;
        logic        fl_good;
    } t_entry;

    // Command broadcast from the controller to every cell at once.
    typedef struct packed {
        logic        wr_en;     // write wr_data into the cell at wr_idx
        logic        standby;   // close every live cell
        logic        shift;     // cells at or past shift_from take their right neighbor
        logic [31:0] now_ms;
    } t_cell_cmd;

endpackage

// ----- hdl/cat_cell.sv -----
// ----------------------------------------------------------------------------
// cat_cell
// One table slot: holds an entry, compares it to the search key and moves
// its right neighbor's entry in when the table compacts.
// ----------------------------------------------------------------------------
module cat_cell (
    input  logic               i_clk,
    input  cat_pkg::t_cell_cmd i_cmd,
    input  logic               i_live,      // slot lies below the entry count
    input  logic               i_sel_wr,    // this slot is the write target
    input  logic               i_sel_shift, // this slot takes its neighbor
    input  cat_pkg::t_entry    i_wr_data,
    input  cat_pkg::t_entry    i_right,
    input  logic [31:0]        i_key,
    output cat_pkg::t_entry    o_entry,
    output logic               o_match
);
    cat_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && i_sel_wr) begin
            r_entry <= i_wr_data;
        end else if (i_cmd.shift && i_sel_shift) begin
            r_entry <= i_right;
        end else if (i_cmd.standby && i_live) begin
            r_entry.fl_open    <= 1'b0;
            r_entry.last_check <= i_cmd.now_ms;
        end
    end

    assign o_entry = r_entry;
    assign o_match = i_live && (r_entry.freq == i_key);
endmodule

// ----- hdl/channel_activity_table.sv -----
// ----------------------------------------------------------------------------
// channel_activity_table
// Scanner frequency table with open-time statistics, built as a row of cells.
// ----------------------------------------------------------------------------
// The result is registered: the held transfer has its key matched in all cells
// at once in ST_IDLE, then ST_WRITE writes the entry back and sets the result.
// A new input transfer is taken only after the result has been handed off, so
// the block never holds more than one item at a time.
// Reset (synchronous, active low) empties the table and forgets the last
// active entry; entry contents are not cleared and never read before written.
// ----------------------------------------------------------------------------
module channel_activity_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: opcode[2:0], freq[34:3], now_ms[66:35], meas_open[67],
    // meas_rssi[83:68], meas_noise[99:84], meas_blacklist[100], slot[106:101]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: hit[0], entry_slot[6:1], entry_freq_out[38:7], entry_is_open[39],
    // entry_is_blacklisted[40], entry_is_good[41], entry_open_total[73:42],
    // entry_first_seen[105:74], entry_last_opened[137:106],
    // entry_rssi_out[153:138], entry_noise_out[169:154], table_count[176:170]
    output logic [183:0] m_axis_tdata
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic { ST_IDLE, ST_WRITE } t_state;

    // Input fields of the held transfer.
    logic [2:0]  r_op;
    logic [31:0] r_freq, r_now;
    logic        r_mopen, r_mblack;
    logic [15:0] r_rssi, r_noise;
    logic [5:0]  r_slot;

    t_state       r_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_last;
    logic          r_last_vld;
    logic          r_ovalid;
    logic [183:0]  r_odata;
    logic          r_busy;  // held transfer not yet written back

    cat_pkg::t_entry   w_entry [TABLE_DEPTH];
    cat_pkg::t_entry   w_right [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match;
    cat_pkg::t_cell_cmd w_cmd;
    cat_pkg::t_entry   w_wr_data;
    logic [IW-1:0]     w_wr_idx, w_shift_from;

    // Lookup result captured in ST_IDLE, before the write.
    logic          r_found;
    logic [IW-1:0] r_fidx;
    logic [IW-1:0] n_fidx;
    logic          n_found;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == TABLE_DEPTH - 1) begin : g_end
                assign w_right[g] = w_entry[g];
            end else begin : g_mid
                assign w_right[g] = w_entry[g+1];
            end
            cat_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_live      (CW'(g) < r_count),
                .i_sel_wr    (w_wr_idx == IW'(g)),
                .i_sel_shift (IW'(g) >= w_shift_from),
                .i_wr_data   (w_wr_data),
                .i_right     (w_right[g]),
                .i_key       (r_freq),
                .o_entry     (w_entry[g]),
                .o_match     (w_match[g])
            );
        end
    endgenerate

    // First matching live slot, lowest index wins.
    always_comb begin
        n_found = 1'b0;
        n_fidx  = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                n_found = 1'b1;
                n_fidx  = IW'(i);
            end
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid && !r_busy;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Work of ST_WRITE: build the written entry and the result.
    cat_pkg::t_entry w_cur, w_upd;
    logic          w_upd_ok;
    logic [IW-1:0] w_uidx;
    logic          w_mo;
    logic [CW-1:0] w_cnt_after;
    logic [IW-1:0] w_slot_i;
    logic          w_slot_ok;

    always_comb begin
        w_slot_i  = IW'(r_slot);
        w_slot_ok = ({1'b0, r_slot} < 7'(r_count)) && (32'(r_slot) < 32'(TABLE_DEPTH));
        w_uidx    = r_found ? r_fidx : IW'(r_count);
        w_upd_ok  = r_found || (r_mopen && (r_count < CW'(TABLE_DEPTH)));
        if (r_found) begin
            w_cur = w_entry[r_fidx];
        end else begin
            w_cur             = '0;
            w_cur.freq        = r_freq;
            w_cur.first_seen  = r_now;
            w_cur.last_check  = r_now;
            w_cur.last_opened = r_now;
            w_cur.noise       = cat_pkg::NOISE_INIT;
            w_cur.fl_open     = 1'b1;
        end
        w_mo  = r_mopen && !(w_cur.fl_black || w_cur.fl_good);
        w_upd = w_cur;
        w_upd.rssi  = r_rssi;
        w_upd.noise = r_noise;
        if (w_cur.fl_open) w_upd.open_total = w_cur.open_total + (r_now - w_cur.last_check);
        if (w_mo) w_upd.last_opened = r_now;
        w_upd.last_check = r_now;
        w_upd.fl_open    = w_mo;
        if (r_mblack) w_upd.fl_black = 1'b1;

        w_cmd        = '0;
        w_cmd.now_ms = r_now;
        w_wr_idx     = w_uidx;
        w_wr_data    = w_upd;
        w_shift_from = w_slot_i;
        w_cnt_after  = r_count;
        if (r_state == ST_WRITE) begin
            case (r_op)
                cat_pkg::OP_UPDATE: begin
                    w_cmd.wr_en = w_upd_ok;
                    if (w_upd_ok && !r_found) w_cnt_after = r_count + 1'b1;
                end
                cat_pkg::OP_BLACK, cat_pkg::OP_GOOD: begin
                    w_wr_idx    = r_last;
                    w_wr_data   = w_entry[r_last];
                    w_wr_data.fl_black = (r_op == cat_pkg::OP_BLACK);
                    w_wr_data.fl_good  = (r_op == cat_pkg::OP_GOOD);
                    w_cmd.wr_en = r_last_vld;
                end
                cat_pkg::OP_STANDBY: w_cmd.standby = 1'b1;
                cat_pkg::OP_CLEAR:   w_cnt_after = '0;
                cat_pkg::OP_REMOVE: begin
                    if (r_count != '0) begin
                        w_cmd.shift = 1'b1;
                        w_cnt_after = r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    logic [183:0] w_res;
    cat_pkg::t_entry w_rep;
    logic w_rep_hit;
    logic [5:0] w_rep_slot;
    always_comb begin
        w_rep      = '0;
        w_rep_hit  = 1'b0;
        w_rep_slot = '0;
        if (r_op == cat_pkg::OP_UPDATE && w_upd_ok) begin
            w_rep = w_upd; w_rep_hit = 1'b1; w_rep_slot = 6'(w_uidx);
        end else if (r_op == cat_pkg::OP_READ) begin
            w_rep_slot = r_slot;
            if (w_slot_ok) begin
                w_rep = w_entry[w_slot_i]; w_rep_hit = 1'b1;
            end
        end
        w_res = {7'd0, 7'(w_cnt_after), w_rep.noise, w_rep.rssi, w_rep.last_opened,
                 w_rep.first_seen, w_rep.open_total, w_rep.fl_good, w_rep.fl_black,
                 w_rep.fl_open, w_rep.freq, w_rep_slot, w_rep_hit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_busy     <= 1'b0;
            r_count    <= '0;
            r_last     <= '0;
            r_last_vld <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                r_op     <= s_axis_tdata[2:0];
                r_freq   <= s_axis_tdata[34:3];
                r_now    <= s_axis_tdata[66:35];
                r_mopen  <= s_axis_tdata[67];
                r_rssi   <= s_axis_tdata[83:68];
                r_noise  <= s_axis_tdata[99:84];
                r_mblack <= s_axis_tdata[100];
                r_slot   <= s_axis_tdata[106:101];
                r_busy   <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (r_busy) begin
                        r_found <= n_found;
                        r_fidx  <= n_fidx;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_count  <= w_cnt_after;
                    r_odata  <= w_res;
                    r_ovalid <= 1'b1;
                    r_busy   <= 1'b0;
                    r_state  <= ST_IDLE;
                    if (r_op == cat_pkg::OP_UPDATE && w_upd_ok && w_cur.fl_open) begin
                        r_last     <= w_uidx;
                        r_last_vld <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/channel_activity_table_checker.sv -----
// ----------------------------------------------------------------------------
// channel_activity_table_checker
// Watches both stream channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Each input transfer runs through a model of the frequency table kept here.
// The model's answer is queued. Each output transfer is checked, field by
// field, against the oldest queued answer.
// ----------------------------------------------------------------------------
module channel_activity_table_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [111:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [183:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [4:0]  pad;
        logic [5:0]  slot;
        logic        blacklist;
        logic [15:0] noise;
        logic [15:0] rssi;
        logic        open;
        logic [31:0] now_ms;
        logic [31:0] freq;
        logic [2:0]  opcode;
    } t_scan_cmd;

    typedef struct packed {
        logic [6:0]  pad;
        logic [6:0]  count;
        logic [15:0] noise;
        logic [15:0] rssi;
        logic [31:0] last_opened;
        logic [31:0] first_seen;
        logic [31:0] open_total;
        logic        good;
        logic        black;
        logic        open;
        logic [31:0] freq;
        logic [5:0]  slot;
        logic        hit;
    } t_scan_report;

    // Shadow copy of the table.
    cat_pkg::t_entry shadow [DEPTH];
    int         live_entries;
    int         active_idx;
    bit         active_known;
    t_scan_report reports_due[$];
    int         fails;
    int         hits;

    function automatic t_scan_report empty_report(logic [5:0] echo);
        t_scan_report r;
        r = '0;
        r.slot = echo;
        r.count = live_entries[6:0];
        return r;
    endfunction

    function automatic t_scan_report entry_report(int k);
        t_scan_report r;
        r = '0;
        r.hit = 1'b1;
        r.slot = k[5:0];
        r.freq = shadow[k].freq;
        r.open = shadow[k].fl_open;
        r.black = shadow[k].fl_black;
        r.good = shadow[k].fl_good;
        r.open_total = shadow[k].open_total;
        r.first_seen = shadow[k].first_seen;
        r.last_opened = shadow[k].last_opened;
        r.rssi = shadow[k].rssi;
        r.noise = shadow[k].noise;
        r.count = live_entries[6:0];
        return r;
    endfunction

    // Applies one command to the shadow table and returns its answer.
    function automatic t_scan_report apply_scan(t_scan_cmd c);
        int  k;
        bit  found;
        bit  squelch;
        found = 0;
        k = 0;
        case (c.opcode)
            cat_pkg::OP_UPDATE: begin
                for (int i = 0; i < live_entries; i++) begin
                    if (!found && shadow[i].freq == c.freq) begin
                        found = 1;
                        k = i;
                    end
                end
                if (!found) begin
                    if (!c.open || live_entries >= DEPTH) return empty_report('0);
                    k = live_entries;
                    live_entries++;
                    shadow[k] = '0;
                    shadow[k].freq = c.freq;
                    shadow[k].first_seen = c.now_ms;
                    shadow[k].last_check = c.now_ms;
                    shadow[k].last_opened = c.now_ms;
                    shadow[k].noise = cat_pkg::NOISE_INIT;
                    shadow[k].fl_open = 1'b1;
                end
                // A marked entry never counts as open.
                squelch = c.open && !(shadow[k].fl_black || shadow[k].fl_good);
                shadow[k].noise = c.noise;
                shadow[k].rssi = c.rssi;
                if (shadow[k].fl_open) begin
                    shadow[k].open_total += c.now_ms - shadow[k].last_check;
                    active_idx = k;
                    active_known = 1;
                end
                if (squelch) shadow[k].last_opened = c.now_ms;
                shadow[k].last_check = c.now_ms;
                shadow[k].fl_open = squelch;
                if (c.blacklist) shadow[k].fl_black = 1'b1;
                return entry_report(k);
            end
            cat_pkg::OP_BLACK: begin
                if (active_known) begin
                    shadow[active_idx].fl_good = 1'b0;
                    shadow[active_idx].fl_black = 1'b1;
                end
            end
            cat_pkg::OP_GOOD: begin
                if (active_known) begin
                    shadow[active_idx].fl_black = 1'b0;
                    shadow[active_idx].fl_good = 1'b1;
                end
            end
            cat_pkg::OP_STANDBY: begin
                for (int i = 0; i < live_entries; i++) begin
                    shadow[i].fl_open = 1'b0;
                    shadow[i].last_check = c.now_ms;
                end
            end
            cat_pkg::OP_CLEAR: live_entries = 0;
            cat_pkg::OP_REMOVE: begin
                if (live_entries > 0) begin
                    for (int i = c.slot; i + 1 < live_entries; i++) shadow[i] = shadow[i + 1];
                    live_entries--;
                end
            end
            cat_pkg::OP_READ: begin
                if (c.slot < live_entries) return entry_report(c.slot);
                return empty_report(c.slot);
            end
            default: ;
        endcase
        return empty_report('0);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    initial begin
        live_entries = 0;
        active_idx = 0;
        active_known = 0;
        fails = 0;
        hits = 0;
    end

    always @(posedge i_clk) begin
        t_scan_report want;
        t_scan_report got;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (reports_due.size() == 0) begin
                    $error("result transfer with no result expected");
                    fails++;
                end else begin
                    want = reports_due.pop_front();
                    hits += int'(got.hit);
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("entry_slot", 32'(want.slot), 32'(got.slot));
                    check_field("entry_freq_out", want.freq, got.freq);
                    check_field("entry_is_open", 32'(want.open), 32'(got.open));
                    check_field("entry_is_blacklisted", 32'(want.black), 32'(got.black));
                    check_field("entry_is_good", 32'(want.good), 32'(got.good));
                    check_field("entry_open_total", want.open_total, got.open_total);
                    check_field("entry_first_seen", want.first_seen, got.first_seen);
                    check_field("entry_last_opened", want.last_opened, got.last_opened);
                    check_field("entry_rssi_out", 32'(want.rssi), 32'(got.rssi));
                    check_field("entry_noise_out", 32'(want.noise), 32'(got.noise));
                    check_field("table_count", 32'(want.count), 32'(got.count));
                    check_field("tdata padding", 32'(want.pad), 32'(got.pad));
                end
            end
            if (i_in_valid && i_in_ready) reports_due.push_back(apply_scan(i_in_data));
        end
    end

    always_comb begin
        o_fail_count = fails;
        o_pending = reports_due.size();
        o_hits = hits;
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the channel activity table.
// ----------------------------------------------------------------------------
// A directed opening touches every opcode and the corner cases of the table.
// Random traffic follows, drawn mostly from a small pool of frequencies so
// the table fills, hits, overflows and is trimmed again. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1750;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: opcode, freq, now_ms, meas_open, meas_rssi, meas_noise,
    // meas_blacklist, slot (lowest bits first).
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: hit, entry_slot, entry_freq_out, entry_is_open,
    // entry_is_blacklisted, entry_is_good, entry_open_total, entry_first_seen,
    // entry_last_opened, entry_rssi_out, entry_noise_out, table_count.
    logic [183:0] m_axis_tdata;

    int fail_count;
    int pending;
    int hit_count;
    int cycle_count = 0;
    int sent_count;
    int quiet_sender;
    logic [31:0] clock_ms;
    logic [31:0] freq_pool [80];

    channel_activity_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    channel_activity_table_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hits       (hit_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Hands one command to the block and returns at the falling edge after
    // its transfer, so the next call can keep tvalid high without a gap.
    task automatic send_scan(logic [2:0] op, logic [31:0] freq, logic [31:0] now,
                             logic open, logic [15:0] rssi, logic [15:0] noise,
                             logic black, logic [5:0] slot);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, slot, black, noise, rssi, open, now, freq, op};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_count++;
    endtask

    // Random idle cycles on the sending side, skipped during the quiet stretch.
    task automatic sender_gap();
        while (!quiet_sender && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic random_scan();
        logic [2:0]  op;
        logic [31:0] freq;
        logic [31:0] now;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60) op = cat_pkg::OP_UPDATE;
        else if (pick < 66) op = cat_pkg::OP_BLACK;
        else if (pick < 72) op = cat_pkg::OP_GOOD;
        else if (pick < 76) op = cat_pkg::OP_STANDBY;
        else if (pick < 78) op = cat_pkg::OP_CLEAR;
        else if (pick < 86) op = cat_pkg::OP_REMOVE;
        else if (pick < 98) op = cat_pkg::OP_READ;
        else op = OP_UNUSED;
        // Most keys repeat so entries get hit again; a few are fresh.
        freq = ($urandom_range(9) == 0) ? $urandom() : freq_pool[$urandom_range(79)];
        clock_ms += $urandom_range(3000);
        now = ($urandom_range(49) == 0) ? $urandom() : clock_ms;
        send_scan(op, freq, now, $urandom_range(99) < 70, 16'($urandom()), 16'($urandom()),
                  $urandom_range(19) == 0, 6'($urandom_range(63)));
    endtask

    // Receiver: random stalls, one long hold-off to back the block up, and a
    // stretch with no stalls at all.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (cycle_count == 3000) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if (cycle_count > 8000 && cycle_count < 10000) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(99) >= 27);
        end
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sent_count = 0;
        quiet_sender = 0;
        clock_ms = 32'hFFFF_0000 + $urandom_range(50000);
        for (int i = 0; i < 80; i++) freq_pool[i] = $urandom();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: marks with no active entry, reads and removes on
        // an empty table, extreme fields, unused opcode, marks after removal.
        send_scan(cat_pkg::OP_BLACK, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_GOOD, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 6'd63);
        send_scan(cat_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_UPDATE, 32'h1234, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_UPDATE, '1, 32'd0, 1, '1, '1, 0, 0);
        send_scan(cat_pkg::OP_UPDATE, 0, '1, 1, 0, 0, 1, '1);
        send_scan(cat_pkg::OP_UPDATE, '1, 32'd5, 1, 16'd7, 16'd9, 0, 0);
        send_scan(cat_pkg::OP_UPDATE, '1, 32'd10, 0, 16'd1, 16'd2, 0, 0);
        send_scan(cat_pkg::OP_BLACK, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_UPDATE, '1, 32'd20, 1, 16'd3, 16'd4, 0, 0);
        send_scan(cat_pkg::OP_GOOD, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_UPDATE, 32'hAAAA_5555, 32'd30, 1, 16'h5555, 16'hAAAA, 0, 0);
        send_scan(cat_pkg::OP_STANDBY, 0, 32'd40, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 6'd1);
        send_scan(cat_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 6'd3);
        send_scan(cat_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 6'd0);
        send_scan(cat_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0, 6'd63);
        send_scan(cat_pkg::OP_BLACK, 0, 0, 0, 0, 0, 0, 0);
        send_scan(OP_UNUSED, '1, '1, 1, '1, '1, 1, '1);
        send_scan(cat_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_GOOD, 0, 0, 0, 0, 0, 0, 0);
        send_scan(cat_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 6'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_sender = (n >= 900 && n < 1100);
            if (n == 1300) begin
                // Let the block drain completely before carrying on.
                s_axis_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            sender_gap();
            random_scan();
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(negedge i_clk);
        $display("Sent %0d commands over all opcodes; %0d results reported an entry.",
                 sent_count, hit_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- channel_activity_table.f -----
hdl/cat_pkg.sv
hdl/cat_cell.sv
hdl/channel_activity_table.sv
tb/channel_activity_table_checker.sv
tb/testbench.sv
